// ===== sv/gfa_pkg.sv =====
// Shared types and constants for the grid rectangle first-fit allocator.
// No dependencies; imported by the top level.
package gfa_pkg;

   // Request codes.
   typedef enum logic [1:0] {
      KIND_FIRST_FIT = 2'd0,
      KIND_ALLOC_AT  = 2'd1,
      KIND_FREE      = 2'd2,
      KIND_CHECK     = 2'd3
   } kind_type;

   // Fixed field widths.
   localparam int POS_W  = 4;
   localparam int SIZE_W = 5;
   localparam int CSR_W  = 5;
   localparam int CSR_IDX_W = 1;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_COLUMNS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_ROWS    = 1'd1;

   // Reset values of the grid size registers.
   localparam logic [CSR_W-1:0] GRID_COLUMNS_RESET = 5'd16;
   localparam logic [CSR_W-1:0] GRID_ROWS_RESET    = 5'd16;

   // Default storage size.
   localparam int DEF_MAX_COLUMNS = 16;
   localparam int DEF_MAX_ROWS    = 16;

endpackage

// ===== sv/grid_rectangle_first_fit_allocator_top.sv =====
// Top level of the grid rectangle first-fit allocator: occupancy memory and sequencer.
// Depends on gfa_pkg.
//
//   channel   | ports                                        | flow control
//   ----------+----------------------------------------------+----------------------------
//   request   | start, busy, req_kind/pos_x/pos_y/size_x/_y  | taken when start && !busy
//   response  | rsp_valid, rsp_ok, rsp_found_x, rsp_found_y  | one-cycle strobe, no stall
//   registers | csr_wr_en, csr_index, csr_wdata              | written on any cycle, no wait
//
// The occupancy bitmap lives in one synchronous memory of MAX_COLUMNS words, one word per
// column, one bit per row. Every column access costs one memory read; reads are issued
// back to back and the write-back of a read-modify-write comes in the cycle after its read.
// A rejected transaction answers straight from idle. Allocate-at and free go straight to
// the write phase; check scans the rectangle's columns and answers from the evaluate state.
// First-fit scans size_x columns for every candidate column tried, then marks the chosen
// rectangle in the write phase and answers, or answers when no column fits.
// Reset is synchronous and clears the per-column valid bits at once, so no clearing pass
// is needed; a word that was never written reads as all free. The receiver cannot stall,
// so each result is shown for exactly one cycle, and busy is low in that cycle.
module grid_rectangle_first_fit_allocator_top #(
   parameter int MAX_COLUMNS = gfa_pkg::DEF_MAX_COLUMNS,
   parameter int MAX_ROWS    = gfa_pkg::DEF_MAX_ROWS
) (
   input  logic                             clock,
   input  logic                             reset,
   // Request transaction.
   input  logic                             start,
   output logic                             busy,
   input  gfa_pkg::kind_type                req_kind,
   input  logic [gfa_pkg::POS_W-1:0]        req_pos_x,
   input  logic [gfa_pkg::POS_W-1:0]        req_pos_y,
   input  logic [gfa_pkg::SIZE_W-1:0]       req_size_x,
   input  logic [gfa_pkg::SIZE_W-1:0]       req_size_y,
   // Response transaction.
   output logic                             rsp_valid,
   output logic                             rsp_ok,
   output logic [gfa_pkg::POS_W-1:0]        rsp_found_x,
   output logic [gfa_pkg::POS_W-1:0]        rsp_found_y,
   // Configuration writes.
   input  logic                             csr_wr_en,
   input  logic [gfa_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [gfa_pkg::CSR_W-1:0]        csr_wdata
);
   import gfa_pkg::*;

   // Count widths hold 0..MAX inclusive; sum widths also hold a position plus a size.
   localparam int CCW = $clog2(MAX_COLUMNS + 1);
   localparam int RCW = $clog2(MAX_ROWS + 1);
   localparam int XSW = ((CCW > SIZE_W) ? CCW : SIZE_W) + 1;
   localparam int YSW = ((RCW > SIZE_W) ? RCW : SIZE_W) + 1;
   localparam int CIW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SCAN_WAIT,
      ST_EVAL,
      ST_WRITE,
      ST_WRITE_WAIT
   } state_type;

   // Configuration registers.
   logic [CSR_W-1:0] cols_ff;
   logic [CSR_W-1:0] rows_ff;

   // Sequencer state and request registers.
   state_type         state_ff;
   kind_type          kind_ff;
   logic [XSW-1:0]    x_ff;
   logic [YSW-1:0]    y_ff;
   logic [SIZE_W-1:0] sx_ff;
   logic [SIZE_W-1:0] sy_ff;
   logic [XSW-1:0]    rd_col_ff;
   logic [MAX_ROWS-1:0] acc_ff;

   // Response registers.
   logic                rsp_valid_ff;
   logic                rsp_ok_ff;
   logic [POS_W-1:0]    rsp_found_x_ff;
   logic [POS_W-1:0]    rsp_found_y_ff;

   // Occupancy memory, its valid bits and the read pipeline.
   logic [MAX_ROWS-1:0] mem [MAX_COLUMNS];
   logic [MAX_COLUMNS-1:0] valid_ff;
   logic [MAX_ROWS-1:0] mem_q_ff;
   logic                mem_q_valid_ff;
   logic                rd_vld_ff;
   logic [CIW-1:0]      wb_addr_ff;

   logic [XSW-1:0]      act_cols;
   logic [YSW-1:0]      act_rows;
   logic                req_fits;
   logic [MAX_ROWS-1:0] low_mask;
   logic [MAX_ROWS-1:0] write_mask;
   logic [MAX_ROWS-1:0] rd_data;
   logic [MAX_ROWS-1:0] wr_data;
   logic [MAX_ROWS-1:0] row_fit;
   logic                any_fit;
   logic [YSW-1:0]      fit_row;
   logic                check_free;
   logic [XSW-1:0]      x_last;
   logic                next_x_fits;
   logic                rd_en;
   logic [CIW-1:0]      rd_addr;
   logic                wr_en;
   logic                accept;

   // Grid sizes saturate to the storage size.
   assign act_cols = (XSW'(cols_ff) > XSW'(MAX_COLUMNS)) ? XSW'(MAX_COLUMNS) : XSW'(cols_ff);
   assign act_rows = (YSW'(rows_ff) > YSW'(MAX_ROWS)) ? YSW'(MAX_ROWS) : YSW'(rows_ff);

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   // A request is rejected outright when a size is zero or the rectangle leaves the grid.
   // First-fit only needs the rectangle to fit somewhere.
   always_comb begin
      req_fits = (req_size_x != '0) && (req_size_y != '0);
      if (req_kind == KIND_FIRST_FIT) begin
         req_fits = req_fits && (XSW'(req_size_x) <= act_cols)
                             && (YSW'(req_size_y) <= act_rows);
      end else begin
         req_fits = req_fits
                    && ((XSW'(req_pos_x) + XSW'(req_size_x)) <= act_cols)
                    && ((YSW'(req_pos_y) + YSW'(req_size_y)) <= act_rows);
      end
   end

   // Ones in the low size_y bits; shifted to the corner row it covers the rectangle.
   always_comb begin
      for (int r = 0; r < MAX_ROWS; r++) begin
         low_mask[r] = (YSW'(r) < YSW'(sy_ff));
      end
   end

   assign write_mask = low_mask << y_ff;
   assign rd_data    = mem_q_valid_ff ? mem_q_ff : '0;
   assign wr_data    = (kind_ff == KIND_FREE) ? (rd_data & ~write_mask)
                                              : (rd_data | write_mask);

   // Candidate corner rows for the union of the current columns; the lowest one wins.
   always_comb begin
      for (int y = 0; y < MAX_ROWS; y++) begin
         row_fit[y] = ((YSW'(y) + YSW'(sy_ff)) <= act_rows)
                      && (((acc_ff >> y) & low_mask) == '0);
      end
   end

   always_comb begin
      fit_row = '0;
      for (int y = MAX_ROWS - 1; y >= 0; y--) begin
         if (row_fit[y]) begin
            fit_row = YSW'(y);
         end
      end
   end

   assign any_fit     = |row_fit;
   assign check_free  = (((acc_ff >> y_ff) & low_mask) == '0);
   assign x_last      = x_ff + XSW'(sx_ff) - XSW'(1);
   assign next_x_fits = (x_ff + XSW'(1) + XSW'(sx_ff)) <= act_cols;

   assign rd_en   = (state_ff == ST_SCAN) || (state_ff == ST_WRITE);
   assign rd_addr = rd_col_ff[CIW-1:0];
   assign wr_en   = rd_vld_ff && ((state_ff == ST_WRITE) || (state_ff == ST_WRITE_WAIT));

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= GRID_COLUMNS_RESET;
         rows_ff <= GRID_ROWS_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_GRID_COLUMNS: cols_ff <= csr_wdata;
            CSR_GRID_ROWS:    rows_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Occupancy memory: one read port, one write port, registered read data.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         mem_q_ff <= mem[rd_addr];
      end
      if (wr_en) begin
         mem[wb_addr_ff] <= wr_data;
      end
   end

   // Per-column valid bits stand in for clearing the memory at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff       <= '0;
         mem_q_valid_ff <= 1'b0;
         rd_vld_ff      <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wb_addr_ff] <= 1'b1;
         end
         if (rd_en) begin
            mem_q_valid_ff <= valid_ff[rd_addr];
         end
         rd_vld_ff <= rd_en;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         wb_addr_ff <= rd_addr;
      end
   end

   // Sequencer. The scan phase ORs the words of size_x columns into acc_ff; the write phase
   // reads the rectangle's columns (again, for first-fit) and writes each back the cycle after.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         rsp_ok_ff      <= 1'b0;
         rsp_found_x_ff <= '0;
         rsp_found_y_ff <= '0;
         kind_ff        <= KIND_FIRST_FIT;
         x_ff           <= '0;
         y_ff           <= '0;
         sx_ff          <= '0;
         sy_ff          <= '0;
         rd_col_ff      <= '0;
         acc_ff         <= '0;
      end else begin
         rsp_valid_ff <= 1'b0;
         if (rd_vld_ff && ((state_ff == ST_SCAN) || (state_ff == ST_SCAN_WAIT))) begin
            acc_ff <= acc_ff | rd_data;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  kind_ff   <= req_kind;
                  sx_ff     <= req_size_x;
                  sy_ff     <= req_size_y;
                  acc_ff    <= '0;
                  if (req_kind == KIND_FIRST_FIT) begin
                     x_ff      <= '0;
                     y_ff      <= '0;
                     rd_col_ff <= '0;
                  end else begin
                     x_ff      <= XSW'(req_pos_x);
                     y_ff      <= YSW'(req_pos_y);
                     rd_col_ff <= XSW'(req_pos_x);
                  end
                  if (!req_fits) begin
                     rsp_valid_ff   <= 1'b1;
                     rsp_ok_ff      <= 1'b0;
                     rsp_found_x_ff <= '0;
                     rsp_found_y_ff <= '0;
                  end else begin
                     case (req_kind) inside
                        KIND_ALLOC_AT, KIND_FREE: state_ff <= ST_WRITE;
                        default:                  state_ff <= ST_SCAN;
                     endcase
                  end
               end
            end
            ST_SCAN: begin
               rd_col_ff <= rd_col_ff + XSW'(1);
               if (rd_col_ff == x_last) begin
                  state_ff <= ST_SCAN_WAIT;
               end
            end
            ST_SCAN_WAIT: begin
               state_ff <= ST_EVAL;
            end
            ST_EVAL: begin
               if (kind_ff == KIND_CHECK) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_ok_ff      <= check_free;
                  rsp_found_x_ff <= check_free ? x_ff[POS_W-1:0] : '0;
                  rsp_found_y_ff <= check_free ? y_ff[POS_W-1:0] : '0;
                  state_ff       <= ST_IDLE;
               end else if (any_fit) begin
                  y_ff      <= fit_row;
                  rd_col_ff <= x_ff;
                  state_ff  <= ST_WRITE;
               end else if (next_x_fits) begin
                  x_ff      <= x_ff + XSW'(1);
                  rd_col_ff <= x_ff + XSW'(1);
                  acc_ff    <= '0;
                  state_ff  <= ST_SCAN;
               end else begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_ok_ff      <= 1'b0;
                  rsp_found_x_ff <= '0;
                  rsp_found_y_ff <= '0;
                  state_ff       <= ST_IDLE;
               end
            end
            ST_WRITE: begin
               rd_col_ff <= rd_col_ff + XSW'(1);
               if (rd_col_ff == x_last) begin
                  state_ff <= ST_WRITE_WAIT;
               end
            end
            ST_WRITE_WAIT: begin
               rsp_valid_ff   <= 1'b1;
               rsp_ok_ff      <= 1'b1;
               rsp_found_x_ff <= x_ff[POS_W-1:0];
               rsp_found_y_ff <= y_ff[POS_W-1:0];
               state_ff       <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_ok      = rsp_ok_ff;
   assign rsp_found_x = rsp_found_x_ff;
   assign rsp_found_y = rsp_found_y_ff;

   // A result only appears once the sequencer is back in idle.
   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == ST_IDLE))
      else $error("response strobe while the sequencer is busy");

   // A failed transaction reports a zero corner.
   a_fail_zero_corner: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ok_ff) |-> (rsp_found_x_ff == '0 && rsp_found_y_ff == '0))
      else $error("failed response carries a nonzero corner");

   // Memory writes happen only in the write phase and never for a check.
   a_write_phase: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (kind_ff != KIND_CHECK))
      else $error("memory written outside an allocate or free");

   // Every accepted transaction either answers at once or keeps the block busy.
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      accept |=> (rsp_valid_ff || busy))
      else $error("accepted transaction dropped");

   // Memory accesses stay inside the active grid.
   a_read_in_grid: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> (rd_col_ff < act_cols))
      else $error("column read beyond the active grid");

endmodule
